@@ design/assert_macros.svh @@
// Assertion macros shared by the console engine modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge out of reset
`define TCCE_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// cons must hold in the same cycle as ante
`define TCCE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define TCCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/tcce_pkg.sv @@
// Shared types, constants and codes for the text console engine
package tcce_pkg;

  localparam int COLUMNS_DEF  = 80;
  localparam int ROWS_DEF     = 25;
  localparam int TAB_STOP_DEF = 8;
  localparam int QUEUE_DEPTH  = 2;

  localparam int ROW_PORT_W   = 5;
  localparam int COL_PORT_W   = 7;
  localparam int CHAR_W       = 8;
  localparam int COLOR_W      = 4;
  localparam int CELL_W       = CHAR_W + 2 * COLOR_W;
  localparam int CFG_IDX_W    = 1;

  localparam logic [CHAR_W-1:0] PRINT_LO   = 8'd32;
  localparam logic [CHAR_W-1:0] PRINT_HI   = 8'd127;
  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_FF    = 8'd12;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'd32;

  localparam logic [COLOR_W-1:0] FORE_RESET = 4'd15;
  localparam logic [COLOR_W-1:0] BACK_RESET = 4'd0;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK_COLOR = 1'd1;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_PRINT,
    CMD_BS,
    CMD_TAB,
    CMD_LF,
    CMD_FF,
    CMD_CR,
    CMD_READ,
    CMD_READ_OOR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic [CHAR_W-1:0]       ch;
    logic [ROW_PORT_W-1:0]   row;
    logic [COL_PORT_W-1:0]   col;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FILL,
    ST_RDATA,
    ST_DONE
  } back_state_t;

endpackage

@@ design/text_console_char_engine.sv @@
// Path: front register, command queue, then the back-end sequencer (idle, execute, done), with an
// extra read-data state for a read of a written row; a scroll and the first write into a cleared row
// each add a row walk (one print may do both). The sequencer handles one request at a time while
// the queue takes new ones; the row walks write the single-port store one cell per cycle.
// Reset: synchronous, active low; all rows read as white-on-black spaces at once,
// no clearing pass. Form feed walks no rows; cleared rows are written out on the first print into them.
module text_console_char_engine #(
  parameter int COLUMNS  = tcce_pkg::COLUMNS_DEF,
  parameter int ROWS     = tcce_pkg::ROWS_DEF,
  parameter int TAB_STOP = tcce_pkg::TAB_STOP_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_operation,
  input  logic [tcce_pkg::CHAR_W-1:0]      in_char_byte,
  input  logic [tcce_pkg::ROW_PORT_W-1:0]  in_read_row,
  input  logic [tcce_pkg::COL_PORT_W-1:0]  in_read_column,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tcce_pkg::ROW_PORT_W-1:0]  out_cursor_row,
  output logic [tcce_pkg::COL_PORT_W-1:0]  out_cursor_column,
  output logic [tcce_pkg::CHAR_W-1:0]      out_cell_char,
  output logic [tcce_pkg::COLOR_W-1:0]     out_cell_fore,
  output logic [tcce_pkg::COLOR_W-1:0]     out_cell_back,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tcce_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tcce_pkg::COLOR_W-1:0]     cfg_data
);
  import tcce_pkg::*;

  logic [COLOR_W-1:0] text_color_r, text_color_nxt;
  logic [COLOR_W-1:0] back_color_r, back_color_nxt;
  q_stat_t            q_stat;
  logic               q_push, q_pop;
  cmd_t               q_in_cmd, q_head;

  assign cfg_ready = 1'b1;

  always_comb begin
    text_color_nxt = text_color_r;
    back_color_nxt = back_color_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TEXT_COLOR: text_color_nxt = cfg_data;
        CFG_BACK_COLOR: back_color_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= FORE_RESET;
      back_color_r <= BACK_RESET;
    end else begin
      text_color_r <= text_color_nxt;
      back_color_r <= back_color_nxt;
    end
  end

  tcce_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_char_byte   (in_char_byte),
    .in_read_row    (in_read_row),
    .in_read_column (in_read_column),
    .q_stat         (q_stat),
    .q_push         (q_push),
    .q_cmd          (q_in_cmd)
  );

  tcce_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in_cmd),
    .pop      (q_pop),
    .head_cmd (q_head),
    .stat     (q_stat)
  );

  tcce_back #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_stat            (q_stat),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .text_color        (text_color_r),
    .back_color        (back_color_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cursor_row    (out_cursor_row),
    .out_cursor_column (out_cursor_column),
    .out_cell_char     (out_cell_char),
    .out_cell_fore     (out_cell_fore),
    .out_cell_back     (out_cell_back)
  );

endmodule

@@ design/tcce_ram.sv @@
// Generic single-port RAM with registered read
module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/tcce_front.sv @@
// Front end: accepts requests, classifies them into commands, feeds the queue
module tcce_front #(
  parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcce_pkg::ROWS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_operation,
  input  logic [tcce_pkg::CHAR_W-1:0]      in_char_byte,
  input  logic [tcce_pkg::ROW_PORT_W-1:0]  in_read_row,
  input  logic [tcce_pkg::COL_PORT_W-1:0]  in_read_column,
  input  tcce_pkg::q_stat_t                q_stat,
  output logic                             q_push,
  output tcce_pkg::cmd_t                   q_cmd
);
  import tcce_pkg::*;

  logic      f_valid_r, f_valid_nxt;
  cmd_t      f_cmd_r, f_cmd_nxt;
  cmd_kind_t kind;
  logic      take;

  always_comb begin
    kind = CMD_NOP;
    if (in_operation == OP_READ) begin
      if (32'(in_read_row) < ROWS && 32'(in_read_column) < COLUMNS) begin
        kind = CMD_READ;
      end else begin
        kind = CMD_READ_OOR;
      end
    end else if (in_char_byte inside {[PRINT_LO:PRINT_HI]}) begin
      kind = CMD_PRINT;
    end else begin
      case (in_char_byte)
        CHAR_BS:  kind = CMD_BS;
        CHAR_TAB: kind = CMD_TAB;
        CHAR_LF:  kind = CMD_LF;
        CHAR_FF:  kind = CMD_FF;
        CHAR_CR:  kind = CMD_CR;
        default:  kind = CMD_NOP;
      endcase
    end
  end

  assign in_stall = f_valid_r && q_stat.full;
  assign take     = in_valid && !in_stall;
  assign q_push   = f_valid_r && !q_stat.full;
  assign q_cmd    = f_cmd_r;

  always_comb begin
    f_valid_nxt = f_valid_r;
    f_cmd_nxt   = f_cmd_r;
    if (take) begin
      f_valid_nxt   = 1'b1;
      f_cmd_nxt.kind = kind;
      f_cmd_nxt.ch   = in_char_byte;
      f_cmd_nxt.row  = in_read_row;
      f_cmd_nxt.col  = in_read_column;
    end else if (q_push) begin
      f_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
    f_cmd_r <= f_cmd_nxt;
  end

endmodule

@@ design/tcce_fifo.sv @@
// Command queue between front end and back end
module tcce_fifo #(
  parameter int DEPTH = tcce_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tcce_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output tcce_pkg::cmd_t    head_cmd,
  output tcce_pkg::q_stat_t stat
);
  import tcce_pkg::*;
  `include "assert_macros.svh"

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [NW-1:0] CNT_FULL = NW'(DEPTH);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] count_r, count_nxt;

  assign stat.full  = (count_r == CNT_FULL);
  assign stat.empty = (count_r == '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  `TCCE_ASSERT_IMPLIES(a_no_overflow, clk, rst_n, push, !stat.full, "push into full queue")
  `TCCE_ASSERT_IMPLIES(a_no_underflow, clk, rst_n, pop, !stat.empty, "pop from empty queue")
  `TCCE_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CNT_FULL, "queue count overrun")

endmodule

@@ design/tcce_back.sv @@
// Back end: executes commands on cursor and character store, holds the result
module tcce_back #(
  parameter int COLUMNS  = tcce_pkg::COLUMNS_DEF,
  parameter int ROWS     = tcce_pkg::ROWS_DEF,
  parameter int TAB_STOP = tcce_pkg::TAB_STOP_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tcce_pkg::q_stat_t                q_stat,
  input  tcce_pkg::cmd_t                   q_head,
  output logic                             q_pop,
  input  logic [tcce_pkg::COLOR_W-1:0]     text_color,
  input  logic [tcce_pkg::COLOR_W-1:0]     back_color,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tcce_pkg::ROW_PORT_W-1:0]  out_cursor_row,
  output logic [tcce_pkg::COL_PORT_W-1:0]  out_cursor_column,
  output logic [tcce_pkg::CHAR_W-1:0]      out_cell_char,
  output logic [tcce_pkg::COLOR_W-1:0]     out_cell_fore,
  output logic [tcce_pkg::COLOR_W-1:0]     out_cell_back
);
  import tcce_pkg::*;
  `include "assert_macros.svh"

  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW = $clog2(COLUMNS);
  localparam int AW = $clog2(ROWS * COLUMNS);
  localparam int TW = CW + 5;
  localparam logic [RW:0]   ROWS_X  = (RW + 1)'(ROWS);
  localparam logic [RW-1:0] ROWS_M1 = RW'(ROWS - 1);
  localparam logic [CW:0]   COLS_X  = (CW + 1)'(COLUMNS);
  localparam logic [CW-1:0] COLS_M1 = CW'(COLUMNS - 1);
  localparam logic [AW-1:0] COLS_A  = AW'(COLUMNS);
  // floor(col / TAB_STOP) as (col * recip) >> 16, exact for col below 256
  localparam logic [16:0]   TAB_RECIP = 17'((1 << 16) / TAB_STOP + 1);
  localparam logic [TW-1:0] TAB_T   = TW'(TAB_STOP);
  localparam logic [TW-1:0] TAB_MAX = TW'(COLUMNS - 1);

  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] base,
                                             input logic [RW-1:0] vis);
    logic [RW:0] s;
    s = {1'b0, base} + {1'b0, vis};
    if (s >= ROWS_X) begin
      s = s - ROWS_X;
    end
    return s[RW-1:0];
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] prow,
                                              input logic [CW-1:0] col);
    return AW'(prow) * COLS_A + AW'(col);
  endfunction

  back_state_t        state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [RW-1:0]      cur_row_r, cur_row_nxt;
  logic [CW-1:0]      cur_col_r, cur_col_nxt;
  logic [RW-1:0]      base_r, base_nxt;
  logic [ROWS-1:0]    row_valid_r, row_valid_nxt;
  logic [COLOR_W-1:0] clr_fore_r, clr_fore_nxt;
  logic [COLOR_W-1:0] clr_back_r, clr_back_nxt;
  logic [RW-1:0]      fill_row_r, fill_row_nxt;
  logic [CW-1:0]      fill_cnt_r, fill_cnt_nxt;
  logic [COLOR_W-1:0] fill_fore_r, fill_fore_nxt;
  logic [COLOR_W-1:0] fill_back_r, fill_back_nxt;
  logic               fill_exec_r, fill_exec_nxt;
  logic [CELL_W-1:0]  cell_r, cell_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [RW-1:0]      out_row_r, out_row_nxt;
  logic [CW-1:0]      out_col_r, out_col_nxt;
  logic [CELL_W-1:0]  out_cell_r, out_cell_nxt;

  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [CELL_W-1:0]  ram_wdata;
  logic [CELL_W-1:0]  ram_rdata;

  logic [RW-1:0]      cur_prow, rd_prow;
  logic [RW-1:0]      rd_row;
  logic [CW-1:0]      rd_col;
  logic [AW-1:0]      cur_addr, rd_addr, fill_addr;
  logic               cur_row_ok, rd_row_ok;
  logic [CW:0]        col_inc;
  logic               wrap, last_row, fill_last, out_free;
  logic               exec_newline, exec_scroll, exec_prefill, read_hit;
  logic [RW-1:0]      base_inc;
  logic [CW+16:0]     tab_prod;
  logic [TW-1:0]      tab_t;

  assign rd_row     = RW'(cmd_r.row);
  assign rd_col     = CW'(cmd_r.col);
  assign cur_prow   = phys_row(base_r, cur_row_r);
  assign rd_prow    = phys_row(base_r, rd_row);
  assign cur_addr   = cell_addr(cur_prow, cur_col_r);
  assign rd_addr    = cell_addr(rd_prow, rd_col);
  assign fill_addr  = cell_addr(fill_row_r, fill_cnt_r);
  assign cur_row_ok = row_valid_r[cur_prow];
  assign rd_row_ok  = row_valid_r[rd_prow];
  assign col_inc    = {1'b0, cur_col_r} + 1'b1;
  assign wrap       = (col_inc >= COLS_X);
  assign last_row   = (cur_row_r == ROWS_M1);
  assign fill_last  = (fill_cnt_r == COLS_M1);
  assign out_free   = !out_valid_r || !out_stall;
  assign base_inc   = (base_r == ROWS_M1) ? '0 : base_r + 1'b1;

  assign tab_prod = (CW + 17)'(cur_col_r) * (CW + 17)'(TAB_RECIP);
  assign tab_t    = TW'(tab_prod[CW+16:16]) * TAB_T + TAB_T;

  assign exec_prefill = (cmd_r.kind == CMD_PRINT) && !cur_row_ok;
  assign exec_newline = ((cmd_r.kind == CMD_PRINT) && cur_row_ok && wrap) ||
                        (cmd_r.kind == CMD_LF);
  assign exec_scroll  = exec_newline && last_row;
  assign read_hit     = (cmd_r.kind == CMD_READ) && rd_row_ok;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_prefill || exec_scroll) begin
          state_nxt = ST_FILL;
        end else if (read_hit) begin
          state_nxt = ST_RDATA;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_FILL: begin
        if (fill_last) begin
          state_nxt = fill_exec_r ? ST_EXEC : ST_DONE;
        end
      end
      ST_RDATA: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = cur_addr;
    ram_wdata     = {back_color, text_color, cmd_r.ch};
    cmd_nxt       = cmd_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    base_nxt      = base_r;
    row_valid_nxt = row_valid_r;
    clr_fore_nxt  = clr_fore_r;
    clr_back_nxt  = clr_back_r;
    fill_row_nxt  = fill_row_r;
    fill_cnt_nxt  = fill_cnt_r;
    fill_fore_nxt = fill_fore_r;
    fill_back_nxt = fill_back_r;
    fill_exec_nxt = fill_exec_r;
    cell_nxt      = cell_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_cell_nxt  = out_cell_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          q_pop   = 1'b1;
          cmd_nxt = q_head;
        end
      end
      ST_EXEC: begin
        cell_nxt = '0;
        case (cmd_r.kind)
          CMD_PRINT: begin
            if (!cur_row_ok) begin
              // row still blank from a clear: write it out first
              fill_row_nxt  = cur_prow;
              fill_cnt_nxt  = '0;
              fill_fore_nxt = clr_fore_r;
              fill_back_nxt = clr_back_r;
              fill_exec_nxt = 1'b1;
            end else begin
              ram_we = 1'b1;
              if (!wrap) begin
                cur_col_nxt = col_inc[CW-1:0];
              end
            end
          end
          CMD_BS: begin
            if (cur_col_r != '0) begin
              cur_col_nxt = cur_col_r - 1'b1;
            end
          end
          CMD_TAB: begin
            cur_col_nxt = (tab_t > TAB_MAX) ? COLS_M1 : tab_t[CW-1:0];
          end
          CMD_FF: begin
            row_valid_nxt = '0;
            clr_fore_nxt  = text_color;
            clr_back_nxt  = back_color;
            base_nxt      = '0;
            cur_row_nxt   = '0;
            cur_col_nxt   = '0;
          end
          CMD_CR: cur_col_nxt = '0;
          CMD_READ: begin
            ram_addr = rd_addr;
            if (!rd_row_ok) begin
              cell_nxt = {clr_back_r, clr_fore_r, BLANK_CHAR};
            end
          end
          default: begin
          end
        endcase
        if (exec_newline) begin
          cur_col_nxt = '0;
          if (last_row) begin
            // new bottom row is the old top physical row
            base_nxt      = base_inc;
            fill_row_nxt  = base_r;
            fill_cnt_nxt  = '0;
            fill_fore_nxt = text_color;
            fill_back_nxt = back_color;
            fill_exec_nxt = 1'b0;
          end else begin
            cur_row_nxt = cur_row_r + 1'b1;
          end
        end
      end
      ST_FILL: begin
        ram_we       = 1'b1;
        ram_addr     = fill_addr;
        ram_wdata    = {fill_back_r, fill_fore_r, BLANK_CHAR};
        fill_cnt_nxt = fill_cnt_r + 1'b1;
        if (fill_last) begin
          row_valid_nxt[fill_row_r] = 1'b1;
          fill_cnt_nxt              = '0;
        end
      end
      ST_RDATA: cell_nxt = ram_rdata;
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = cur_row_r;
          out_col_nxt   = cur_col_r;
          out_cell_nxt  = cell_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      base_r      <= '0;
      row_valid_r <= '0;
      clr_fore_r  <= FORE_RESET;
      clr_back_r  <= BACK_RESET;
      fill_cnt_r  <= '0;
      fill_exec_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      base_r      <= base_nxt;
      row_valid_r <= row_valid_nxt;
      clr_fore_r  <= clr_fore_nxt;
      clr_back_r  <= clr_back_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      fill_exec_r <= fill_exec_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r       <= cmd_nxt;
    fill_row_r  <= fill_row_nxt;
    fill_fore_r <= fill_fore_nxt;
    fill_back_r <= fill_back_nxt;
    cell_r      <= cell_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    out_cell_r  <= out_cell_nxt;
  end

  tcce_ram #(
    .WIDTH (CELL_W),
    .DEPTH (ROWS * COLUMNS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign out_valid         = out_valid_r;
  assign out_cursor_row    = ROW_PORT_W'(out_row_r);
  assign out_cursor_column = COL_PORT_W'(out_col_r);
  assign out_cell_char     = out_cell_r[CHAR_W-1:0];
  assign out_cell_fore     = out_cell_r[CHAR_W+COLOR_W-1:CHAR_W];
  assign out_cell_back     = out_cell_r[CELL_W-1:CHAR_W+COLOR_W];

  `TCCE_ASSERT_ALWAYS(a_cursor_range, clk, rst_n,
    ({1'b0, cur_row_r} < ROWS_X) && ({1'b0, cur_col_r} < COLS_X), "cursor out of screen")
  `TCCE_ASSERT_ALWAYS(a_base_range, clk, rst_n, {1'b0, base_r} < ROWS_X, "base row out of range")
  `TCCE_ASSERT_NEXT(a_fill_marks_row, clk, rst_n, (state_r == ST_FILL) && fill_last,
    row_valid_r[$past(fill_row_r)], "filled row not marked written")
  `TCCE_ASSERT_IMPLIES(a_pop_idle, clk, rst_n, q_pop,
    (state_r == ST_IDLE) && !q_stat.empty, "pop outside idle")
  `TCCE_ASSERT_NEXT(a_done_loads, clk, rst_n, (state_r == ST_DONE) && out_free,
    out_valid_r && (state_r == ST_IDLE), "result not loaded")

endmodule
